// File: design/cholesky_factor_lower_rows_assert.svh
// Assertion macros for the Cholesky row factoriser.
`ifndef CHOLESKY_FACTOR_LOWER_ROWS_ASSERT_SVH
`define CHOLESKY_FACTOR_LOWER_ROWS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CHLR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/chlr_pkg.sv
// Shared constants, types and helpers of the Cholesky row factoriser.
`default_nettype none
package chlr_pkg;

    localparam int MAX_ORDER  = 8;
    localparam int FRAC_BITS  = 16;
    localparam int WORD_W     = 32;
    localparam int ACC_W      = 64;
    localparam int SIZE_W     = 4;
    localparam int IDX_W      = $clog2(MAX_ORDER);
    localparam int CNT_W      = $clog2(MAX_ORDER + 1);
    localparam int TRI_DEPTH  = MAX_ORDER * (MAX_ORDER + 1) / 2;
    localparam int TRI_W      = $clog2(TRI_DEPTH);
    localparam int FIFO_DEPTH = 2;
    localparam int STEP_W     = $clog2(ACC_W);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

    // shared unit operation codes
    localparam logic MODE_DIV  = 1'b0;
    localparam logic MODE_SQRT = 1'b1;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [TRI_W-1:0]         t_taddr;

    localparam t_word WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // one classified element travelling from front to back
    typedef struct packed {
        t_word value;
        t_idx  row;
        t_idx  col;
        logic  diag;
        logic  clr;
        logic  last;
    } t_item;

    // packed-triangle address of entry (r, c)
    function automatic t_taddr tri_addr(t_idx r, t_idx c);
        logic [2*IDX_W:0] w;
        w = ((2*IDX_W+1)'(r) * ((2*IDX_W+1)'(r) + 1'b1)) >> 1;
        return TRI_W'(w + (2*IDX_W+1)'(c));
    endfunction

endpackage
`default_nettype wire

// File: design/chlr_front.sv
// Front end: takes element beats, tracks the matrix position, classifies.
`default_nettype none
module chlr_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire chlr_pkg::t_word         i_element_value,
    input  wire                          i_matrix_start,
    input  wire [chlr_pkg::SIZE_W-1:0]   i_matrix_size,
    input  wire                          i_full,
    output logic                         o_push,
    output chlr_pkg::t_item              o_item
);

    logic [chlr_pkg::CNT_W-1:0] n_ord;
    chlr_pkg::t_idx r_row, r_col;
    chlr_pkg::t_idx cur_i, cur_j;
    logic start, wrap, diag;

    // order in force, clamped to 1..MAX_ORDER
    always_comb begin
        if (i_matrix_size == '0) begin
            n_ord = chlr_pkg::CNT_W'(1);
        end else if (32'(i_matrix_size) > chlr_pkg::MAX_ORDER) begin
            n_ord = chlr_pkg::CNT_W'(chlr_pkg::MAX_ORDER);
        end else begin
            n_ord = chlr_pkg::CNT_W'(i_matrix_size);
        end
    end

    // position of this beat
    always_comb begin
        start = i_matrix_start || (chlr_pkg::CNT_W'(r_row) >= n_ord);
        cur_i = start ? '0 : r_row;
        cur_j = start ? '0 : r_col;
        if (cur_j > cur_i) begin
            cur_j = cur_i;
        end
        diag = (cur_j == cur_i);
        wrap = (chlr_pkg::CNT_W'(cur_i) + 1'b1) >= n_ord;
    end

    assign o_in_ready   = !i_full;
    assign o_push       = i_in_valid && !i_full;
    assign o_item.value = i_element_value;
    assign o_item.row   = cur_i;
    assign o_item.col   = cur_j;
    assign o_item.diag  = diag;
    assign o_item.clr   = start;
    assign o_item.last  = diag && wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (o_push) begin
            if (!diag) begin
                r_col <= cur_j + 1'b1;
                r_row <= cur_i;
            end else begin
                r_col <= '0;
                r_row <= wrap ? '0 : cur_i + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: design/chlr_fifo.sv
// Short queue between front and back.
`default_nettype none
module chlr_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire chlr_pkg::t_item i_item,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_valid,
    output chlr_pkg::t_item     o_item
);

    localparam int PTR_W = (chlr_pkg::FIFO_DEPTH > 1) ? $clog2(chlr_pkg::FIFO_DEPTH) : 1;
    localparam int CT_W  = $clog2(chlr_pkg::FIFO_DEPTH + 1);

    chlr_pkg::t_item r_mem [chlr_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CT_W-1:0]  r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == CT_W'(chlr_pkg::FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
        return (p == PTR_W'(chlr_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= bump(r_wp);
            end
            if (do_pop) begin
                r_rp <= bump(r_rp);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: design/chlr_divsqrt.sv
// Shared iterative unit: signed 64/32 division or 64-bit integer square root.
`default_nettype none
module chlr_divsqrt (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_start,
    input  wire             i_mode,
    input  wire chlr_pkg::t_acc  i_acc,
    input  wire chlr_pkg::t_word i_divisor,
    output logic            o_done,
    output chlr_pkg::t_word o_result
);

    localparam int AW = chlr_pkg::ACC_W;
    localparam int WW = chlr_pkg::WORD_W;

    logic                          r_busy, r_mode, r_neg, r_done;
    logic [chlr_pkg::STEP_W-1:0]   r_cnt;
    logic [WW-1:0]                 r_den, r_rem;
    logic [AW-1:0]                 r_q, r_v, r_bit;
    chlr_pkg::t_word               r_result;

    logic [WW:0]   rem_sh;
    logic          d_ge, s_ge;
    logic [WW-1:0] n_rem;
    logic [AW-1:0] n_q, n_v, sum, mag_a;
    logic [WW-1:0] mag_d;
    chlr_pkg::t_word fin;

    assign mag_a = i_acc[AW-1] ? AW'(-i_acc) : AW'(i_acc);
    assign mag_d = i_divisor[WW-1] ? WW'(-i_divisor) : WW'(i_divisor);

    // one restoring step or one root digit
    always_comb begin
        rem_sh = {r_rem, r_q[AW-1]};
        d_ge   = rem_sh >= {1'b0, r_den};
        n_rem  = d_ge ? WW'(rem_sh - {1'b0, r_den}) : rem_sh[WW-1:0];
        sum    = r_q + r_bit;
        s_ge   = r_v >= sum;
        n_v    = s_ge ? r_v - sum : r_v;
        if (r_mode == chlr_pkg::MODE_DIV) begin
            n_q = {r_q[AW-2:0], d_ge};
        end else begin
            n_q = s_ge ? (r_q >> 1) + r_bit : (r_q >> 1);
        end
    end

    // sign and saturate the finished magnitude
    always_comb begin
        if (r_mode == chlr_pkg::MODE_SQRT) begin
            fin = (n_q > AW'(chlr_pkg::WORD_MAX)) ? chlr_pkg::WORD_MAX : WW'(n_q);
        end else if (!r_neg) begin
            fin = (n_q > AW'(chlr_pkg::WORD_MAX)) ? chlr_pkg::WORD_MAX : WW'(n_q);
        end else begin
            fin = (n_q > (AW'(chlr_pkg::WORD_MAX) + 1'b1)) ? chlr_pkg::WORD_MIN
                                                          : WW'(-n_q);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_mode <= i_mode;
                r_rem  <= '0;
                if (i_mode == chlr_pkg::MODE_DIV) begin
                    r_neg <= i_acc[AW-1] ^ i_divisor[WW-1];
                    r_q   <= mag_a;
                    r_den <= mag_d;
                    r_cnt <= chlr_pkg::STEP_W'(AW - 1);
                    if (i_divisor == '0) begin
                        r_done   <= 1'b1;
                        r_result <= i_acc[AW-1] ? chlr_pkg::WORD_MIN : chlr_pkg::WORD_MAX;
                    end else begin
                        r_busy <= 1'b1;
                    end
                end else begin
                    r_v    <= AW'(i_acc);
                    r_q    <= '0;
                    r_bit  <= AW'(1) << (AW - 2);
                    r_cnt  <= chlr_pkg::STEP_W'(AW / 2 - 1);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_v   <= n_v;
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy   <= 1'b0;
                    r_done   <= 1'b1;
                    r_result <= fin;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: design/chlr_back.sv
// Back end: multiply-accumulate over stored L, divide or root, emit the row.
`default_nettype none
module chlr_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_head_valid,
    input  wire chlr_pkg::t_item i_head,
    output logic                o_pop,
    output logic                o_ds_start,
    output logic                o_ds_mode,
    output chlr_pkg::t_acc      o_ds_acc,
    output chlr_pkg::t_word     o_ds_divisor,
    input  wire                 i_ds_done,
    input  wire chlr_pkg::t_word i_ds_result,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output chlr_pkg::t_word     o_factor_value,
    output chlr_pkg::t_idx      o_row_index,
    output chlr_pkg::t_idx      o_col_index,
    output logic                o_row_done,
    output logic                o_status
);

    localparam int AW = chlr_pkg::ACC_W;
    localparam int WW = chlr_pkg::WORD_W;
    localparam int FB = chlr_pkg::FRAC_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIAG = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_WAIT = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0]       r_state;
    chlr_pkg::t_item  r_item;
    logic             r_failed, r_fail, r_out_valid;
    chlr_pkg::t_idx   r_k, cnt;
    chlr_pkg::t_acc   r_acc, r_prod, n_acc;
    chlr_pkg::t_word  r_divisor, r_rb, r_dres, r_mem_q;
    chlr_pkg::t_word  r_out_val;
    chlr_pkg::t_idx   r_out_row, r_out_col;
    logic             r_out_done, r_out_st;

    chlr_pkg::t_word  r_mem [chlr_pkg::TRI_DEPTH];
    chlr_pkg::t_word  r_rowbuf [chlr_pkg::MAX_ORDER];

    chlr_pkg::t_taddr mem_ra, mem_wa;
    logic             mem_we, failed_eff, emit_fire, emit_last, acc_pos;
    chlr_pkg::t_word  emit_val, mul_b, fail_val;
    chlr_pkg::t_acc   mul, a_ext, a_scaled, fail_adj, fail_q;
    logic [AW:0]      diff;

    assign cnt        = r_item.diag ? r_item.row : r_item.col;
    assign o_pop      = (r_state == S_IDLE) && i_head_valid;
    assign failed_eff = i_head.clr ? 1'b0 : r_failed;
    assign emit_fire  = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign emit_last  = (r_k == r_item.row);
    assign emit_val   = emit_last ? r_dres : r_rowbuf[r_k];
    assign acc_pos    = !r_acc[AW-1] && (r_acc != '0);

    // input scaled to Q(2*FRAC_BITS)
    assign a_ext    = {{(AW-WW){i_head.value[WW-1]}}, i_head.value};
    assign a_scaled = {a_ext[AW-FB-1:0], {FB{1'b0}}};

    // product and saturating subtract
    assign mul_b = r_item.diag ? r_rb : r_mem_q;
    assign mul   = r_rb * mul_b;
    assign diff  = {r_acc[AW-1], r_acc} - {r_prod[AW-1], r_prod};
    always_comb begin
        if (diff[AW] != diff[AW-1]) begin
            n_acc = diff[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end else begin
            n_acc = diff[AW-1:0];
        end
    end

    // reduced diagonal of a failed row, truncated toward zero
    assign fail_adj = r_acc + (r_acc[AW-1] ? AW'((64'd1 << FB) - 64'd1) : AW'(0));
    assign fail_q   = fail_adj >>> FB;
    assign fail_val = (fail_q < AW'(chlr_pkg::WORD_MIN)) ? chlr_pkg::WORD_MIN : WW'(fail_q);

    // shared unit hand-off
    assign o_ds_start   = (r_state == S_FIN) && (!r_item.diag || acc_pos);
    assign o_ds_mode    = r_item.diag ? chlr_pkg::MODE_SQRT : chlr_pkg::MODE_DIV;
    assign o_ds_acc     = r_acc;
    assign o_ds_divisor = r_divisor;

    // triangle store: one read, one write
    assign mem_ra = (r_state == S_IDLE) ? chlr_pkg::tri_addr(i_head.col, i_head.col)
                                        : chlr_pkg::tri_addr(r_item.col, r_k);
    assign mem_wa = chlr_pkg::tri_addr(r_item.row, r_k);
    assign mem_we = emit_fire && !r_fail;

    always_ff @(posedge i_clk) begin
        r_mem_q <= r_mem[mem_ra];
        if (mem_we) begin
            r_mem[mem_wa] <= emit_val;
        end
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_fire) begin
                r_out_valid <= 1'b1;
                r_out_val   <= emit_val;
                r_out_row   <= r_item.row;
                r_out_col   <= r_k;
                r_out_done  <= emit_last;
                r_out_st    <= r_fail;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_item <= i_head;
                        r_k    <= '0;
                        r_acc  <= a_scaled;
                        if (failed_eff) begin
                            r_failed <= !i_head.last;
                        end else begin
                            r_failed <= 1'b0;
                            r_state  <= S_DIAG;
                        end
                    end
                end
                S_DIAG: begin
                    r_divisor <= r_mem_q;
                    r_state   <= (cnt == '0) ? S_FIN : S_RD;
                end
                S_RD: begin
                    r_rb    <= r_rowbuf[r_k];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= mul;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= n_acc;
                    r_k     <= r_k + 1'b1;
                    r_state <= (r_k + 1'b1 == cnt) ? S_FIN : S_RD;
                end
                S_FIN: begin
                    if (o_ds_start) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_dres  <= fail_val;
                        r_fail  <= 1'b1;
                        r_k     <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_WAIT: begin
                    if (i_ds_done) begin
                        if (!r_item.diag) begin
                            r_rowbuf[r_item.col] <= i_ds_result;
                            r_state <= S_IDLE;
                        end else begin
                            r_dres  <= i_ds_result;
                            r_fail  <= 1'b0;
                            r_k     <= '0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (emit_fire) begin
                        if (emit_last) begin
                            r_failed <= r_fail && !r_item.last;
                            r_state  <= S_IDLE;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_factor_value = r_out_val;
    assign o_row_index    = r_out_row;
    assign o_col_index    = r_out_col;
    assign o_row_done     = r_out_done;
    assign o_status       = r_out_st;

endmodule
`default_nettype wire

// File: design/cholesky_factor_lower_rows.sv
// Top level of the streaming lower Cholesky row factoriser.
// Usage:
//  - Input channel (i_in_valid / o_in_ready): one beat per lower-triangle
//    entry, row-major, Q16.16. i_matrix_start restarts at row 0, column 0.
//  - Output channel (o_out_valid / i_out_ready): on a row's diagonal beat the
//    whole row of L is sent, columns 0..i, o_row_done on the last beat,
//    o_status set on every beat of a row that is not positive definite.
//  - Config channel (i_cfg_valid / o_cfg_ready): matrix order, write when idle.
//  - Flow: an off-diagonal entry in column j runs a multiply-accumulate loop
//    of read, multiply and accumulate states over j terms, then the 64-step divider.
//    A diagonal of row i runs the loop over i terms and the 32-step root, then
//    i + 1 output beats. Elements are worked one at a time; a two-entry
//    queue lets input beats land while the back end is busy.
//  - Reset clears position, failure flag, queue and output valid; matrix
//    order returns to 8. The L store needs no clearing.
//  - A stalled receiver holds the current result; the back end waits and the
//    queue then back-pressures the input channel.
`default_nettype none
module cholesky_factor_lower_rows (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire [chlr_pkg::SIZE_W-1:0]  i_cfg_matrix_size,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire signed [31:0]           i_element_value,
    input  wire                         i_matrix_start,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic signed [31:0]          o_factor_value,
    output logic [2:0]                  o_row_index,
    output logic [2:0]                  o_col_index,
    output logic                        o_row_done,
    output logic                        o_status
);

    logic [chlr_pkg::SIZE_W-1:0] r_matrix_size;
    logic            push, full, pop, head_valid;
    chlr_pkg::t_item push_item, head_item;
    logic            ds_start, ds_mode, ds_done;
    chlr_pkg::t_acc  ds_acc;
    chlr_pkg::t_word ds_divisor, ds_result;

    // order register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= chlr_pkg::SIZE_RESET;
        end else if (i_cfg_valid) begin
            r_matrix_size <= i_cfg_matrix_size;
        end
    end

    chlr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_element_value (i_element_value),
        .i_matrix_start  (i_matrix_start),
        .i_matrix_size   (r_matrix_size),
        .i_full          (full),
        .o_push          (push),
        .o_item          (push_item)
    );

    chlr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_item  (head_item)
    );

    chlr_divsqrt u_divsqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (ds_start),
        .i_mode    (ds_mode),
        .i_acc     (ds_acc),
        .i_divisor (ds_divisor),
        .o_done    (ds_done),
        .o_result  (ds_result)
    );

    chlr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (head_valid),
        .i_head         (head_item),
        .o_pop          (pop),
        .o_ds_start     (ds_start),
        .o_ds_mode      (ds_mode),
        .o_ds_acc       (ds_acc),
        .o_ds_divisor   (ds_divisor),
        .i_ds_done      (ds_done),
        .i_ds_result    (ds_result),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_factor_value (o_factor_value),
        .o_row_index    (o_row_index),
        .o_col_index    (o_col_index),
        .o_row_done     (o_row_done),
        .o_status       (o_status)
    );

`include "cholesky_factor_lower_rows_assert.svh"

    // diagonal beat sits on the diagonal
    `CHLR_ASSERT_NOW(a_diag_pos, i_clk, i_rst_n, o_out_valid && o_row_done, o_col_index == o_row_index, "diagonal beat off the diagonal")
    // off-diagonal beats lie strictly below it
    `CHLR_ASSERT_NOW(a_off_pos, i_clk, i_rst_n, o_out_valid && !o_row_done, o_col_index < o_row_index, "off-diagonal beat not below diagonal")
    // a good diagonal is a positive root
    `CHLR_ASSERT_NOW(a_root_pos, i_clk, i_rst_n, o_out_valid && o_row_done && !o_status, !o_factor_value[31] && (o_factor_value != '0), "diagonal root not positive")
    // a row streams without gaps once its first beat is taken
    `CHLR_ASSERT_NEXT(a_row_burst, i_clk, i_rst_n, o_out_valid && !o_row_done && i_out_ready, o_out_valid, "gap inside a row burst")

endmodule
`default_nettype wire

// File: test/tb_top.sv
// Testbench for the streaming lower Cholesky row factoriser: stimulus, predictor and checks.
`timescale 1ns / 1ps
module tb_top;
    import chlr_pkg::*;

    typedef struct {
        t_word      val;
        logic [2:0] row;
        logic [2:0] col;
        logic       done;
        logic       st;
    } t_lbeat;

    typedef struct {
        t_word val;
        logic  start;
        logic  chk;
        t_word exp_val;
        logic  exp_st;
    } t_stim;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [SIZE_W-1:0]    i_cfg_matrix_size = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic signed [31:0]   i_element_value = '0;
    logic                 i_matrix_start = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic signed [31:0]   o_factor_value;
    logic [2:0]           o_row_index;
    logic [2:0]           o_col_index;
    logic                 o_row_done;
    logic                 o_status;

    cholesky_factor_lower_rows dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_matrix_size (i_cfg_matrix_size),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_element_value   (i_element_value),
        .i_matrix_start    (i_matrix_start),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_factor_value    (o_factor_value),
        .o_row_index       (o_row_index),
        .o_col_index       (o_col_index),
        .o_row_done        (o_row_done),
        .o_status          (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("tb_top: done, errors");
        $finish;
    end

    // predictor state
    t_word           l_tri [TRI_DEPTH];
    t_word           row_part [MAX_ORDER];
    int unsigned     cur_row, cur_col;
    logic            swallowing;
    logic [3:0]      order_reg;
    t_lbeat          l_rows_due[$];
    int              n_errors = 0;
    logic            calm = 1'b0;   // phase with no idling on either side

    function automatic int unsigned tri_at(int unsigned r, int unsigned c);
        return r * (r + 1) / 2 + c;
    endfunction

    function automatic int unsigned order_now();
        if (order_reg == 0) return 1;
        if (order_reg > MAX_ORDER) return MAX_ORDER;
        return order_reg;
    endfunction

    function automatic longint acc_minus(longint a, longint b);
        if (b > 0 && a < (64'sh8000_0000_0000_0000 + b)) return 64'sh8000_0000_0000_0000;
        if (b < 0 && a > (64'sh7FFF_FFFF_FFFF_FFFF + b)) return 64'sh7FFF_FFFF_FFFF_FFFF;
        return a - b;
    endfunction

    function automatic t_word clip32(longint v);
        if (v > 64'sd2147483647) return WORD_MAX;
        if (v < -64'sd2147483648) return WORD_MIN;
        return t_word'(v);
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] res, b;
        res = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // advance the factoriser by one element; keep == 0 drops the row beats
    task automatic factor_elem(t_word a, logic start, logic keep);
        int unsigned n, i, j;
        longint acc;
        t_word d;
        logic bad;
        n = order_now();
        if (start || cur_row >= n) begin
            cur_row = 0;
            cur_col = 0;
            swallowing = 1'b0;
        end
        i = cur_row;
        j = (cur_col > i) ? i : cur_col;
        if (!swallowing) begin
            acc = longint'(a) * 64'sd65536;
            if (j < i) begin
                for (int k = 0; k < j; k++)
                    acc = acc_minus(acc, longint'(row_part[k]) * longint'(l_tri[tri_at(j, k)]));
                d = l_tri[tri_at(j, j)];
                if (d == 0) row_part[j] = (acc >= 0) ? WORD_MAX : WORD_MIN;
                else        row_part[j] = clip32(acc / longint'(d));
            end else begin
                for (int k = 0; k < i; k++)
                    acc = acc_minus(acc, longint'(row_part[k]) * longint'(row_part[k]));
                bad = (acc <= 0);
                d = bad ? clip32(acc / 64'sd65536) : clip32(longint'(root64(acc)));
                for (int k = 0; k < i; k++) begin
                    if (!bad) l_tri[tri_at(i, k)] = row_part[k];
                    if (keep) l_rows_due.push_back('{row_part[k], i[2:0], k[2:0], 1'b0, bad});
                end
                if (!bad) l_tri[tri_at(i, i)] = d;
                if (keep) l_rows_due.push_back('{d, i[2:0], i[2:0], 1'b1, bad});
                swallowing = bad;
            end
        end
        if (j < i) begin
            cur_col = j + 1;
        end else begin
            cur_col = 0;
            cur_row = i + 1;
            if (cur_row >= n) begin
                cur_row = 0;
                swallowing = 1'b0;
            end
        end
    endtask

    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_miss(string what);
        n_errors++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    // receiver stalls
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0 && !calm) begin
                i_out_ready <= 1'b0;
                hold--;
            end else begin
                i_out_ready <= 1'b1;
                hold = ($urandom_range(0, 5) == 0) ? gap_len() : 0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_lbeat e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (l_rows_due.size() == 0) begin
                report_miss($sformatf("unexpected beat r%0d c%0d", o_row_index, o_col_index));
            end else begin
                e = l_rows_due.pop_front();
                if (o_factor_value !== e.val)
                    report_miss($sformatf("r%0d c%0d value %h want %h",
                        e.row, e.col, o_factor_value, e.val));
                if (o_row_index !== e.row)
                    report_miss($sformatf("row %0d want %0d", o_row_index, e.row));
                if (o_col_index !== e.col)
                    report_miss($sformatf("col %0d want %0d", o_col_index, e.col));
                if (o_row_done !== e.done)
                    report_miss($sformatf("r%0d c%0d row_done %b", e.row, e.col, o_row_done));
                if (o_status !== e.st)
                    report_miss($sformatf("r%0d c%0d status %b", e.row, e.col, o_status));
            end
        end
    end

    task automatic send_elem(t_word v, logic start, logic keep);
        repeat (gap_len()) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_element_value <= v;
        i_matrix_start  <= start;
        do @(posedge i_clk); while (!o_in_ready);
        factor_elem(v, start, keep);
    endtask

    // up to three off-diagonal elements can still be in flight once the last row has left
    task automatic drain_then_write(logic [3:0] sz);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (l_rows_due.size() == 0);
        repeat (600) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_matrix_size <= sz;
        do @(posedge i_clk); while (!o_cfg_ready);
        order_reg = sz;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one matrix of the order in force with random content, positive definite unless the diagonals are fully random
    task automatic send_matrix();
        int unsigned n;
        t_word v;
        logic wild;
        n = order_now();
        wild = ($urandom_range(0, 5) == 0);
        for (int i = 0; i < n; i++)
            for (int j = 0; j <= i; j++) begin
                if (j < i) v = t_word'($urandom_range(0, 1 << 19)) - 32'sh0004_0000;
                else if (wild) v = t_word'($urandom);
                else v = 32'sh0040_0000 + t_word'($urandom_range(0, 1 << 20));
                send_elem(v, (i == 0 && j == 0) ? ($urandom_range(0, 3) != 0) : 1'b0, 1'b1);
            end
    endtask

    t_stim directed[13] = '{
        '{32'sh0001_0000, 1'b1, 1'b1, 32'sh0001_0000, 1'b0},  // unit diagonal
        '{32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000, 1'b1},  // most negative: fails
        '{32'sh1234_5678, 1'b0, 1'b0, 32'sh0,         1'b0},  // swallowed
        '{32'sh0000_0000, 1'b1, 1'b1, 32'sh0,         1'b1},  // zero diagonal fails
        '{32'sh0004_0000, 1'b1, 1'b1, 32'sh0002_0000, 1'b0},
        '{32'sh0002_0000, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{32'sh0005_0000, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{32'sh7FFF_FFFF, 1'b0, 1'b0, 32'sh0,         1'b0},  // extreme off-diagonals
        '{32'sh8000_0000, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{32'sh7FFF_FFFF, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{32'sh0000_0001, 1'b1, 1'b1, 32'sh0000_0100, 1'b0},  // one LSB
        '{32'sh7FFF_FFFF, 1'b1, 1'b0, 32'sh0,         1'b0},
        '{32'shFFFF_FFFF, 1'b1, 1'b1, 32'shFFFF_FFFF, 1'b1}   // minus one LSB
    };

    logic [3:0] phase_size[8] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd2, 4'd8, 4'd5};

    initial begin
        int sent;
        for (int k = 0; k < TRI_DEPTH; k++) l_tri[k] = '0;
        for (int k = 0; k < MAX_ORDER; k++) row_part[k] = '0;
        cur_row = 0;
        cur_col = 0;
        swallowing = 1'b0;
        order_reg = SIZE_RESET;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows, size as after reset
        foreach (directed[d]) begin
            send_elem(directed[d].val, directed[d].start, !directed[d].chk);
            if (directed[d].chk)
                l_rows_due.push_back('{directed[d].exp_val, 3'd0, 3'd0, 1'b1, directed[d].exp_st});
        end

        foreach (phase_size[p]) begin
            if (p != 0) drain_then_write(phase_size[p]);
            calm = (p % 3 == 2);
            sent = 0;
            while (sent < 45) begin
                if ($urandom_range(0, 4) != 0) begin
                    send_matrix();
                    sent += order_now() * (order_now() + 1) / 2;
                end else begin
                    repeat ($urandom_range(1, 5)) begin
                        send_elem(t_word'($urandom), ($urandom_range(0, 3) == 0), 1'b1);
                        sent++;
                    end
                end
            end
            // leave a matrix half done so a smaller size restarts it
            repeat ($urandom_range(1, 4)) begin
                send_elem(32'sh0010_0000 + t_word'($urandom_range(0, 1 << 18)), 1'b0, 1'b1);
                sent++;
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (l_rows_due.size() == 0);
        repeat (300) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/chlr_pkg.sv
design/chlr_front.sv
design/chlr_fifo.sv
design/chlr_divsqrt.sv
design/chlr_back.sv
design/cholesky_factor_lower_rows.sv
test/tb_top.sv
